FILE: src/dbc_pkg.sv
// ----------------------------------------------------------------------------
// Trigger debounce and capture package
// Shared widths, debounce patterns and item types for the trigger input
// debounce and capture block.
// ----------------------------------------------------------------------------
package dbc_pkg;

    // Number of debounced jacks, one lane each.
    localparam int NUM_JACKS = 5;

    // Fixed field widths.
    localparam int LEVEL_W = 5;
    localparam int CV_W    = 12;
    localparam int TIME_W  = 32;
    localparam int NUM_PLAY = 2;
    localparam int FADE_W  = 2;

    // Sample history length and the patterns that it is compared against.
    localparam int HIST_W = 13;
    localparam logic [HIST_W-1:0] TRIG_PATTERN    = 13'h1ffe;
    localparam logic [HIST_W-1:0] RELEASE_PATTERN = 13'h00ff;

    // One input item.
    typedef struct packed {
        logic [LEVEL_W-1:0] jack_levels;
        logic [CV_W-1:0]    cv_sample_a;
        logic [CV_W-1:0]    cv_sample_b;
        logic [TIME_W-1:0]  time_now;
        logic               playing_a;
        logic               playing_b;
    } in_item_t;

    // One result item.
    typedef struct packed {
        logic [LEVEL_W-1:0] trigger_pulses;
        logic [LEVEL_W-1:0] debounced_down;
        logic [FADE_W-1:0]  fade_request;
        logic [CV_W-1:0]    latched_cv_a;
        logic [CV_W-1:0]    latched_cv_b;
        logic [TIME_W-1:0]  trigger_time_a;
        logic [TIME_W-1:0]  trigger_time_b;
    } out_item_t;

    // What one lane found on the current item.
    typedef struct packed {
        logic trig;
        logic up;
    } lane_event_t;

endpackage

FILE: src/dbc_in_if.sv
// ----------------------------------------------------------------------------
// Input item channel
// Valid/ready channel that carries one sampled tick per item.
// ----------------------------------------------------------------------------
interface dbc_in_if import dbc_pkg::*; ();

    logic     valid;
    logic     ready;
    in_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);

endinterface

FILE: src/dbc_out_if.sv
// ----------------------------------------------------------------------------
// Result item channel
// Valid/ready channel that carries one debounce result per item.
// ----------------------------------------------------------------------------
interface dbc_out_if import dbc_pkg::*; ();

    logic      valid;
    logic      ready;
    out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);

endinterface

FILE: src/dbc_lane.sv
// ----------------------------------------------------------------------------
// Debounce lane
// Holds the sample history of one jack and flags the trigger and release
// patterns on the history that the current item produces.
// ----------------------------------------------------------------------------
module dbc_lane import dbc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        advance,
    input  logic        low_in,
    output lane_event_t event_out
);

    logic [HIST_W-1:0] hist_reg;
    logic [HIST_W-1:0] hist_next;

    // The new sample enters at bit 0.
    assign hist_next = {hist_reg[HIST_W-2:0], low_in};

    // Pattern compare on the updated history.
    always_comb
    begin
        event_out.trig = (hist_next == TRIG_PATTERN);
        event_out.up   = (hist_next == RELEASE_PATTERN);
    end

    // History register, shifted once per accepted item.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist_reg <= '0;
        end
        else if (advance)
        begin
            hist_reg <= hist_next;
        end
    end

endmodule

FILE: src/dbc_merge.sv
// ----------------------------------------------------------------------------
// Lane merge and result buffer
// Combines the lane events into the down marks, the play channel captures
// and the fade requests, and buffers results in a two-entry output stage.
// ----------------------------------------------------------------------------
module dbc_merge import dbc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        advance,
    input  in_item_t    item,
    input  lane_event_t lane_ev [NUM_JACKS],
    output logic        in_ready,
    dbc_out_if.source   result
);

    logic [NUM_JACKS-1:0] down_reg;
    logic [NUM_JACKS-1:0] down_next;
    logic [CV_W-1:0]      cv_latch_reg [NUM_PLAY];
    logic [CV_W-1:0]      cv_latch_next [NUM_PLAY];
    logic [TIME_W-1:0]    stamp_reg [NUM_PLAY];
    logic [TIME_W-1:0]    stamp_next [NUM_PLAY];
    logic [LEVEL_W-1:0]   pulses;
    logic [LEVEL_W-1:0]   down_out;
    logic [FADE_W-1:0]    fade;
    logic [CV_W-1:0]      cv_in [NUM_PLAY];
    logic                 playing_in [NUM_PLAY];
    out_item_t            new_item;

    out_item_t out_reg;
    logic      out_valid_reg;
    out_item_t skid_reg;
    logic      skid_valid_reg;
    logic      pop;

    // Per-channel views of the input item.
    assign cv_in[0]      = item.cv_sample_a;
    assign cv_in[1]      = item.cv_sample_b;
    assign playing_in[0] = item.playing_a;
    assign playing_in[1] = item.playing_b;

    // Down marks: a trigger sets the mark, a release pattern clears it.
    genvar j;
    generate
        for (j = 0; j < NUM_JACKS; j++)
        begin : g_down
            assign down_next[j] = lane_ev[j].trig ? 1'b1 :
                                  lane_ev[j].up   ? 1'b0 : down_reg[j];
        end

        // Only the first jacks appear in the result fields.
        for (j = 0; j < LEVEL_W; j++)
        begin : g_out_bits
            if (j < NUM_JACKS)
            begin : g_used
                assign pulses[j]   = lane_ev[j].trig;
                assign down_out[j] = down_next[j];
            end
            else
            begin : g_absent
                assign pulses[j]   = 1'b0;
                assign down_out[j] = 1'b0;
            end
        end

        // Play channels capture CV and time on their trigger.
        for (j = 0; j < NUM_PLAY; j++)
        begin : g_play
            if (j < NUM_JACKS)
            begin : g_has_jack
                assign fade[j]          = lane_ev[j].trig & playing_in[j];
                assign cv_latch_next[j] = lane_ev[j].trig ? cv_in[j] : cv_latch_reg[j];
                assign stamp_next[j]    = lane_ev[j].trig ? item.time_now : stamp_reg[j];
            end
            else
            begin : g_no_jack
                assign fade[j]          = 1'b0;
                assign cv_latch_next[j] = cv_latch_reg[j];
                assign stamp_next[j]    = stamp_reg[j];
            end
        end
    endgenerate

    // Assemble the result of the current item.
    always_comb
    begin
        new_item.trigger_pulses = pulses;
        new_item.debounced_down = down_out;
        new_item.fade_request   = fade;
        new_item.latched_cv_a   = cv_latch_next[0];
        new_item.latched_cv_b   = cv_latch_next[1];
        new_item.trigger_time_a = stamp_next[0];
        new_item.trigger_time_b = stamp_next[1];
    end

    // Debounce and capture state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            down_reg <= '0;
            for (int c = 0; c < NUM_PLAY; c++)
            begin
                cv_latch_reg[c] <= '0;
                stamp_reg[c]    <= '0;
            end
        end
        else if (advance)
        begin
            down_reg <= down_next;
            for (int c = 0; c < NUM_PLAY; c++)
            begin
                cv_latch_reg[c] <= cv_latch_next[c];
                stamp_reg[c]    <= stamp_next[c];
            end
        end
    end

    // Two-entry output buffer; input stalls only when both entries are full.
    assign in_ready     = !skid_valid_reg;
    assign pop          = out_valid_reg && result.ready;
    assign result.valid = out_valid_reg;
    assign result.data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg)
        begin
            out_valid_reg <= advance;
        end
        else if (pop)
        begin
            if (skid_valid_reg)
            begin
                skid_valid_reg <= advance;
            end
            else
            begin
                out_valid_reg <= advance;
            end
        end
        else if (advance)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    // Buffer payload, steered the same way as the valid bits above.
    always_ff @(posedge clk)
    begin
        if (!out_valid_reg)
        begin
            out_reg <= new_item;
        end
        else if (pop)
        begin
            if (skid_valid_reg)
            begin
                out_reg  <= skid_reg;
                skid_reg <= new_item;
            end
            else
            begin
                out_reg <= new_item;
            end
        end
        else if (advance)
        begin
            skid_reg <= new_item;
        end
    end

endmodule

FILE: src/trigger_input_debounce_capture_top.sv
// ----------------------------------------------------------------------------
// Trigger input debounce and capture, top level
// One debounce lane per jack side by side, followed by the lane merge and
// the two-entry result buffer.
// ----------------------------------------------------------------------------
// The block takes one tick item per clock while input ready is high and
// returns exactly one result item for each. The result is presented in the
// cycle after the item is accepted, unless earlier results are still waiting
// on a stalled result side. Every jack has its own 13-bit history lane, and
// all lanes shift and compare in the same cycle, so the rate is one item per
// clock. A two-entry output buffer lets new items flow in while a result
// waits; input ready drops only when both entries are held by a stalled
// result side. Reset clears all histories, marks every jack up and zeroes
// the latched CV values and trigger times.
module trigger_input_debounce_capture_top import dbc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    dbc_in_if.sink   sample,
    dbc_out_if.source result
);

    logic        advance;
    logic        in_ready;
    lane_event_t lane_ev [NUM_JACKS];

    assign sample.ready = in_ready;
    assign advance      = sample.valid && in_ready;

    // One debounce lane per jack; jacks past the level field read low.
    genvar i;
    generate
        for (i = 0; i < NUM_JACKS; i++)
        begin : g_lane
            logic low;
            if (i < LEVEL_W)
            begin : g_wired
                assign low = ~sample.data.jack_levels[i];
            end
            else
            begin : g_open
                assign low = 1'b1;
            end

            dbc_lane u_lane (
                .clk       (clk),
                .rst_n     (rst_n),
                .advance   (advance),
                .low_in    (low),
                .event_out (lane_ev[i])
            );
        end
    endgenerate

    // Merge the lane results and buffer the outgoing items.
    dbc_merge u_merge (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (advance),
        .item     (sample.data),
        .lane_ev  (lane_ev),
        .in_ready (in_ready),
        .result   (result)
    );

endmodule
